[rtl/core/dlnc_pkg.sv]
// ----------------------------------------------------------------------------
// Directory listing name cache package
// Shared codes, default sizes, the line-end struct and the character fold.
// ----------------------------------------------------------------------------
package dlnc_pkg;

  localparam int DEF_LINE_CHARS  = 41;
  localparam int DEF_NAME_MAX    = 16;
  localparam int DEF_CACHE_BYTES = 509;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef struct packed {
    logic active;
    logic fin;
    logic cand;
  } line_end_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (r >= 8'h61 && r <= 8'h7A) begin
      r = r - 8'h20;
    end
    if (r >= 8'hC1 && r <= 8'hDA) begin
      r = r - 8'h80;
    end
    return r;
  endfunction

endpackage

[rtl/core/dlnc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/dlnc_parser.sv]
// ----------------------------------------------------------------------------
// Directory line parser
// Tracks link, block count and text of each line and captures the quoted
// name and its type.
// ----------------------------------------------------------------------------
module dlnc_parser
  import dlnc_pkg::*;
#(
  parameter int LINE_CHARS = DEF_LINE_CHARS,
  parameter int NAME_MAX   = DEF_NAME_MAX,
  localparam int LEN_W = $clog2(NAME_MAX + 2),
  localparam int CHR_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       byte_i,
  output line_end_t        end_o,
  output logic [LEN_W-1:0] name_len_o,
  output logic             nwr_en_o,
  output logic [CHR_W-1:0] nwr_addr_o,
  output logic [7:0]       nwr_data_o
);

  localparam int TL_W = $clog2(LINE_CHARS + 1);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LINK_LO = 3'd1;
  localparam logic [2:0] PH_LINK_HI = 3'd2;
  localparam logic [2:0] PH_BLK_LO  = 3'd3;
  localparam logic [2:0] PH_BLK_HI  = 3'd4;
  localparam logic [2:0] PH_TEXT    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  localparam logic [2:0] Q_NONE  = 3'd0;
  localparam logic [2:0] Q_NAME  = 3'd1;
  localparam logic [2:0] Q_SPACE = 3'd2;
  localparam logic [2:0] Q_STAR  = 3'd3;
  localparam logic [2:0] Q_TYPE1 = 3'd4;
  localparam logic [2:0] Q_REST  = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic             first_q, first_d;
  logic [7:0]       link_q, link_d;
  logic [TL_W-1:0]  tlen_q, tlen_d;
  logic [2:0]       qp_q, qp_d;
  logic [LEN_W-1:0] nlen_q, nlen_d;
  logic [7:0]       t0_q, t0_d;
  logic [7:0]       t1_q, t1_d;
  logic             clear_line;
  logic             feed;

  always_comb begin
    phase_d    = phase_q;
    first_d    = first_q;
    link_d     = link_q;
    tlen_d     = tlen_q;
    qp_d       = qp_q;
    nlen_d     = nlen_q;
    t0_d       = t0_q;
    t1_d       = t1_q;
    clear_line = 1'b0;
    feed       = 1'b0;
    end_o.active = (phase_q != PH_IDLE);
    end_o.fin    = 1'b0;
    end_o.cand   = !first_q && (qp_q >= Q_SPACE) &&
                   !((fold(t0_q) == CH_N) && (fold(t1_q) == CH_F));
    nwr_en_o   = 1'b0;
    nwr_addr_o = nlen_q[CHR_W-1:0];
    nwr_data_o = byte_i;

    if (acc_i) begin
      unique case (cmd_i)
        CMD_START: begin
          phase_d    = PH_LINK_LO;
          first_d    = 1'b1;
          link_d     = 8'd0;
          clear_line = 1'b1;
        end
        CMD_BYTE: begin
          unique case (phase_q)
            PH_LINK_LO: begin
              link_d  = byte_i;
              phase_d = PH_LINK_HI;
            end
            PH_LINK_HI: begin
              phase_d = (link_q == 8'd0 && byte_i == 8'd0) ? PH_DONE : PH_BLK_LO;
            end
            PH_BLK_LO: begin
              phase_d = PH_BLK_HI;
            end
            PH_BLK_HI: begin
              clear_line = 1'b1;
              phase_d    = PH_TEXT;
            end
            PH_TEXT: begin
              if (byte_i == 8'd0) begin
                end_o.fin  = 1'b1;
                first_d    = 1'b0;
                clear_line = 1'b1;
                phase_d    = PH_LINK_LO;
              end else if (tlen_q < TL_W'(LINE_CHARS)) begin
                tlen_d = tlen_q + TL_W'(1);
                feed   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_END: begin
          if (phase_q != PH_IDLE) begin
            if (phase_q == PH_TEXT) begin
              end_o.fin  = 1'b1;
              first_d    = 1'b0;
              clear_line = 1'b1;
            end
            phase_d = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end

    if (feed) begin
      unique case (qp_q)
        Q_NONE: begin
          if (byte_i == CH_QUOTE) begin
            qp_d = Q_NAME;
          end
        end
        Q_NAME: begin
          if (byte_i == CH_QUOTE) begin
            qp_d = Q_SPACE;
          end else begin
            if (nlen_q < LEN_W'(NAME_MAX)) begin
              nwr_en_o = 1'b1;
            end
            if (nlen_q <= LEN_W'(NAME_MAX)) begin
              nlen_d = nlen_q + LEN_W'(1);
            end
          end
        end
        Q_SPACE: begin
          if (byte_i == CH_STAR) begin
            qp_d = Q_STAR;
          end else if (byte_i != CH_SPACE) begin
            t0_d = byte_i;
            qp_d = Q_TYPE1;
          end
        end
        Q_STAR: begin
          t0_d = byte_i;
          qp_d = Q_TYPE1;
        end
        Q_TYPE1: begin
          t1_d = byte_i;
          qp_d = Q_REST;
        end
        default: begin
        end
      endcase
    end

    if (clear_line) begin
      tlen_d = '0;
      qp_d   = Q_NONE;
      nlen_d = '0;
      t0_d   = 8'd0;
      t1_d   = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      first_q <= 1'b1;
      link_q  <= 8'd0;
      tlen_q  <= '0;
      qp_q    <= Q_NONE;
      nlen_q  <= '0;
      t0_q    <= 8'd0;
      t1_q    <= 8'd0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      link_q  <= link_d;
      tlen_q  <= tlen_d;
      qp_q    <= qp_d;
      nlen_q  <= nlen_d;
      t0_q    <= t0_d;
      t1_q    <= t1_d;
    end
  end

  assign name_len_o = nlen_q;

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nlen_q <= LEN_W'(NAME_MAX + 1))
    else $error("name length passed its saturation value");

  a_text_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlen_q <= TL_W'(LINE_CHARS))
    else $error("text length passed the line limit");

  a_name_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nwr_en_o |-> (qp_q == Q_NAME) && (phase_q == PH_TEXT))
    else $error("name buffer written outside a quoted name");

endmodule

[rtl/core/dir_listing_name_cache.sv]
// ----------------------------------------------------------------------------
// Directory listing name cache
// Parses a directory byte stream and writes each kept file name to a packed
// cache as a length byte followed by its upper-folded characters.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tuser: cmd; tdata: byte, error
//   m_axis   out  m_axis_tvalid/tready      tuser: write flag; tdata: result
//
// An item that writes nothing gives only the status result. An item that ends
// a kept name gives a cache write for the length byte and one per character,
// then the status result, as a single sequencer drives the output register
// and reads the name buffer one character a cycle unless the output stalls.
// Reset clears the parser and the cache counters; the name buffer is not
// cleared. A stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
module dir_listing_name_cache
  import dlnc_pkg::*;
#(
  parameter int LINE_CHARS  = DEF_LINE_CHARS,
  parameter int NAME_MAX    = DEF_NAME_MAX,
  parameter int CACHE_BYTES = DEF_CACHE_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte[7:0], read_error[8]
  input  logic [1:0]             s_axis_tuser,  // cmd[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // cache_addr[8:0], cache_data[16:9],
                                                // name_count[24:17], cache_valid[25]
  output logic                   m_axis_tuser,  // write_enable
  output logic                   m_axis_tlast   // last
);

  localparam int LEN_W = $clog2(NAME_MAX + 2);
  localparam int CHR_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int OFF_W = ($clog2(CACHE_BYTES) > 9) ? $clog2(CACHE_BYTES) : 9;
  localparam int SUM_W = OFF_W + 1;

  localparam logic [1:0] SQ_IDLE   = 2'd0;
  localparam logic [1:0] SQ_EMIT   = 2'd1;
  localparam logic [1:0] SQ_STATUS = 2'd2;

  logic [1:0]       seq_q, seq_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [7:0]       names_q, names_d;
  logic             valid_q, valid_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] chr_q, chr_d;
  logic             len_done_q, len_done_d;

  logic             mv_q, mv_d;
  logic             owe_q, owe_d;
  logic [8:0]       oaddr_q, oaddr_d;
  logic [7:0]       odata_q, odata_d;
  logic [7:0]       ocount_q, ocount_d;
  logic             ovalid_q, ovalid_d;
  logic             olast_q, olast_d;

  logic             acc;
  logic             fire;
  logic             keep;
  line_end_t        le;
  logic [LEN_W-1:0] name_len;
  logic             nwr_en;
  logic [CHR_W-1:0] nwr_addr;
  logic [7:0]       nwr_data;
  logic [7:0]       rdata;

  assign s_axis_tready = (seq_q == SQ_IDLE);
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign fire = !mv_q || m_axis_tready;

  dlnc_parser #(
    .LINE_CHARS(LINE_CHARS),
    .NAME_MAX  (NAME_MAX)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .cmd_i     (s_axis_tuser),
    .byte_i    (s_axis_tdata[7:0]),
    .end_o     (le),
    .name_len_o(name_len),
    .nwr_en_o  (nwr_en),
    .nwr_addr_o(nwr_addr),
    .nwr_data_o(nwr_data)
  );

  dlnc_ram #(
    .WIDTH(8),
    .DEPTH(NAME_MAX)
  ) u_name_ram (
    .clk_i  (clk_i),
    .we_i   (nwr_en),
    .waddr_i(nwr_addr),
    .wdata_i(nwr_data),
    .raddr_i(chr_d[CHR_W-1:0]),
    .rdata_o(rdata)
  );

  assign keep = le.fin && le.cand && (name_len != '0) &&
                (name_len <= LEN_W'(NAME_MAX)) &&
                (({1'b0, off_q} + SUM_W'(name_len)) < SUM_W'(CACHE_BYTES)) &&
                (names_q != 8'hFF);

  always_comb begin
    seq_d      = seq_q;
    off_d      = off_q;
    names_d    = names_q;
    valid_d    = valid_q;
    len_d      = len_q;
    chr_d      = chr_q;
    len_done_d = len_done_q;
    mv_d       = mv_q && !m_axis_tready;
    owe_d      = owe_q;
    oaddr_d    = oaddr_q;
    odata_d    = odata_q;
    ocount_d   = ocount_q;
    ovalid_d   = ovalid_q;
    olast_d    = olast_q;

    unique case (seq_q)
      SQ_IDLE: begin
        if (acc) begin
          unique case (s_axis_tuser)
            CMD_START: begin
              off_d   = '0;
              names_d = 8'd0;
              valid_d = 1'b0;
            end
            CMD_END: begin
              if (le.active && !s_axis_tdata[8]) begin
                valid_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (keep) begin
            names_d    = names_q + 8'd1;
            len_d      = name_len;
            chr_d      = '0;
            len_done_d = 1'b0;
            seq_d      = SQ_EMIT;
          end else begin
            seq_d = SQ_STATUS;
          end
        end
      end
      SQ_EMIT: begin
        if (fire) begin
          mv_d     = 1'b1;
          owe_d    = 1'b1;
          oaddr_d  = off_q[8:0];
          ocount_d = names_q;
          ovalid_d = valid_q;
          olast_d  = 1'b0;
          off_d    = off_q + OFF_W'(1);
          if (!len_done_q) begin
            odata_d    = 8'(len_q);
            len_done_d = 1'b1;
          end else begin
            odata_d = fold(rdata);
            if (chr_q == len_q - LEN_W'(1)) begin
              seq_d = SQ_STATUS;
            end else begin
              chr_d = chr_q + LEN_W'(1);
            end
          end
        end
      end
      SQ_STATUS: begin
        if (fire) begin
          mv_d     = 1'b1;
          owe_d    = 1'b0;
          oaddr_d  = off_q[8:0];
          odata_d  = 8'd0;
          ocount_d = names_q;
          ovalid_d = valid_q;
          olast_d  = 1'b1;
          seq_d    = SQ_IDLE;
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= SQ_IDLE;
      off_q      <= '0;
      names_q    <= 8'd0;
      valid_q    <= 1'b0;
      len_q      <= '0;
      chr_q      <= '0;
      len_done_q <= 1'b0;
      mv_q       <= 1'b0;
    end else begin
      seq_q      <= seq_d;
      off_q      <= off_d;
      names_q    <= names_d;
      valid_q    <= valid_d;
      len_q      <= len_d;
      chr_q      <= chr_d;
      len_done_q <= len_done_d;
      mv_q       <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owe_q    <= owe_d;
    oaddr_q  <= oaddr_d;
    odata_q  <= odata_d;
    ocount_q <= ocount_d;
    ovalid_q <= ovalid_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = owe_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {6'd0, ovalid_q, ocount_q, odata_q, oaddr_q};

  a_keep_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && keep) |=> (seq_q == SQ_EMIT) && (len_q != '0))
    else $error("kept name did not start the write sequence");

  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_EMIT) |-> (off_q < OFF_W'(CACHE_BYTES)))
    else $error("cache offset left the cache during a write");

  a_chr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_EMIT) |-> (chr_q < len_q))
    else $error("character index passed the name length");

  a_names_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (names_q != $past(names_q)) |->
      (names_q == $past(names_q) + 8'd1) || (names_q == 8'd0))
    else $error("name count changed by more than one");

  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && owe_q) |-> !olast_q)
    else $error("cache write marked as the final result");

endmodule
